### rtl/core/salc_pkg.sv
// Shared constants and types for the set-associative LRU tag unit.
`timescale 1ns / 1ps

package salc_pkg;

  // Default geometry of the cache level
  localparam int NUM_SETS_DEFAULT    = 64;
  localparam int MAX_WAYS_DEFAULT    = 8;
  localparam int BLOCK_BYTES_DEFAULT = 64;

  // Fixed address width of the access port
  localparam int ADDR_BITS = 32;

  // Width and reset value of the ways-in-use register
  localparam int          WAYS_CFG_W = 4;
  localparam logic [3:0]  WAYS_RESET = 4'd8;

  // Outcome flags of one set lookup
  typedef struct packed {
    logic hit;
    logic evict;
  } lookup_flags_t;

endpackage

### rtl/core/set_assoc_lru_cache_tags_unit.sv
// Top level of the set-associative cache tag unit with true LRU replacement.
//
// Each input transaction carries a byte address. The address is split into
// block offset, set index and tag; the indexed set is looked up and updated.
// Each input yields exactly one output transaction: hit, evicted_valid,
// evicted_address (block-aligned address of a replaced valid line, else 0)
// and miss_count (saturating count of misses including this access).
// The edge that accepts an address also reads its set's row into the memory
// output register, and the edge on which the lookup stage fires registers
// compare, update and write-back, raising out_valid. The next address is
// taken in the cycle the current one finishes, so the unit sustains one
// transaction per cycle while out_ready stays high; a following access to
// the same set takes the just-written row from a forwarding register.
// While out_ready is low, a finished result holds in the output register,
// the lookup stage holds behind it and in_ready drops.
// Reset clears the miss count, sets ways in use to eight and marks every set
// as untouched (all lines invalid, ways ranked zero to seven); this takes
// effect at once, with no clearing pass. cfg_wr_en writes ways in use.
`timescale 1ns / 1ps

module set_assoc_lru_cache_tags_unit #(
  parameter int NUM_SETS    = salc_pkg::NUM_SETS_DEFAULT,
  parameter int MAX_WAYS    = salc_pkg::MAX_WAYS_DEFAULT,
  parameter int BLOCK_BYTES = salc_pkg::BLOCK_BYTES_DEFAULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_wr_en,
  input  logic [salc_pkg::WAYS_CFG_W-1:0] cfg_wr_data,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [salc_pkg::ADDR_BITS-1:0] address,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic                           hit,
  output logic                           evicted_valid,
  output logic [salc_pkg::ADDR_BITS-1:0] evicted_address,
  output logic [31:0]                    miss_count
);

  localparam int AW    = salc_pkg::ADDR_BITS;
  localparam int OFF_W = $clog2(BLOCK_BYTES);
  localparam int IDX_W = $clog2(NUM_SETS);
  localparam int SET_W = (IDX_W > 0) ? IDX_W : 1;
  localparam int TAG_W = AW - OFF_W - IDX_W;
  localparam int WAY_W = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1;
  localparam int CNT_W = $clog2(MAX_WAYS + 1);
  localparam int ROW_W = MAX_WAYS * (TAG_W + 1 + WAY_W);

  logic [salc_pkg::WAYS_CFG_W-1:0] ways_in_use;
  logic [CNT_W-1:0] eff_ways;
  logic [NUM_SETS-1:0] row_init;
  logic [31:0]      miss_counter;
  logic [31:0]      miss_counter_next;

  logic             in_fire;
  logic [SET_W-1:0] in_set;
  logic [TAG_W-1:0] in_tag;

  logic             s1_valid;
  logic             s1_fire;
  logic [SET_W-1:0] s1_set;
  logic [TAG_W-1:0] s1_tag;
  logic             s1_fwd;
  logic             s1_init;

  logic [ROW_W-1:0] rd_row;
  logic [ROW_W-1:0] wb_row;
  logic [ROW_W-1:0] lk_row_in;
  logic [ROW_W-1:0] lk_row_out;
  logic [TAG_W-1:0] victim_tag;
  salc_pkg::lookup_flags_t lk_flags;

  // Hold the ways-in-use register
  always_ff @(posedge clk) begin
    if (rst) begin
      ways_in_use <= salc_pkg::WAYS_RESET;
    end else if (cfg_wr_en) begin
      ways_in_use <= cfg_wr_data;
    end
  end

  // Clamp ways in use to one through MAX_WAYS
  always_comb begin
    if (ways_in_use == '0) begin
      eff_ways = CNT_W'(1);
    end else if (int'(ways_in_use) > MAX_WAYS) begin
      eff_ways = CNT_W'(MAX_WAYS);
    end else begin
      eff_ways = CNT_W'(ways_in_use);
    end
  end

  // Split the address into set index and tag
  assign in_set = (IDX_W > 0) ? SET_W'((address >> OFF_W) & AW'(NUM_SETS - 1)) : '0;
  assign in_tag = TAG_W'(address >> (OFF_W + IDX_W));

  // Advance when the output register is free or being drained
  assign s1_fire  = s1_valid && (!out_valid || out_ready);
  assign in_ready = !s1_valid || s1_fire;
  assign in_fire  = in_valid && in_ready;

  // Lookup stage control
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_fire) begin
      s1_valid <= 1'b1;
    end else if (s1_fire) begin
      s1_valid <= 1'b0;
    end
  end

  // Capture the transaction and whether its row is being written right now
  always_ff @(posedge clk) begin
    if (in_fire) begin
      s1_set  <= in_set;
      s1_tag  <= in_tag;
      s1_fwd  <= s1_fire && (s1_set == in_set);
      s1_init <= row_init[in_set];
    end
  end

  // Mark sets that have been written since reset
  always_ff @(posedge clk) begin
    if (rst) begin
      row_init <= '0;
    end else if (s1_fire) begin
      row_init[s1_set] <= 1'b1;
    end
  end

  // Keep the last written row for forwarding
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      wb_row <= lk_row_out;
    end
  end

  salc_tag_mem #(
    .DEPTH (NUM_SETS),
    .WIDTH (ROW_W)
  ) u_mem (
    .clk     (clk),
    .rd_en   (in_fire),
    .rd_addr (in_set),
    .rd_data (rd_row),
    .wr_en   (s1_fire),
    .wr_addr (s1_set),
    .wr_data (lk_row_out)
  );

  assign lk_row_in = s1_fwd ? wb_row : rd_row;

  salc_lookup #(
    .MAX_WAYS (MAX_WAYS),
    .TAG_W    (TAG_W),
    .WAY_W    (WAY_W),
    .CNT_W    (CNT_W),
    .ROW_W    (ROW_W)
  ) u_lookup (
    .row_in     (lk_row_in),
    .row_fresh  (s1_fwd || s1_init),
    .tag        (s1_tag),
    .eff_ways   (eff_ways),
    .row_out    (lk_row_out),
    .victim_tag (victim_tag),
    .flags      (lk_flags)
  );

  // Saturating miss count
  assign miss_counter_next = (!lk_flags.hit && (miss_counter != '1)) ?
                             miss_counter + 32'd1 : miss_counter;

  always_ff @(posedge clk) begin
    if (rst) begin
      miss_counter <= '0;
    end else if (s1_fire) begin
      miss_counter <= miss_counter_next;
    end
  end

  // Output register control
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Load the result payload
  always_ff @(posedge clk) begin
    if (s1_fire) begin
      hit           <= lk_flags.hit;
      evicted_valid <= lk_flags.evict;
      evicted_address <= lk_flags.evict ?
        ((AW'(victim_tag) << (OFF_W + IDX_W)) | (AW'(s1_set) << OFF_W)) : '0;
      miss_count    <= miss_counter_next;
    end
  end

  // A finished lookup always lands in the output register
  assert property (@(posedge clk) disable iff (rst) s1_fire |=> out_valid)
    else $error("lookup result not registered");

  // Never take a new address while the lookup stage is blocked
  assert property (@(posedge clk) disable iff (rst)
    (s1_valid && !s1_fire) |-> !in_fire)
    else $error("address accepted over a held lookup");

  // A hit never reports an eviction
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && hit) |-> !evicted_valid)
    else $error("eviction reported on a hit");

  // The shown miss count tracks the running counter
  assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (miss_count == miss_counter))
    else $error("miss count out of step with counter");

endmodule

### rtl/core/salc_tag_mem.sv
// Row memory of the tag unit: one write port, one registered read port.
`timescale 1ns / 1ps

module salc_tag_mem #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 192
) (
  input  logic                             clk,
  input  logic                             rd_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] rd_addr,
  output logic [WIDTH-1:0]                 rd_data,
  input  logic                             wr_en,
  input  logic [$clog2(DEPTH > 1 ? DEPTH : 2)-1:0] wr_addr,
  input  logic [WIDTH-1:0]                 wr_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write the row
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // Read the row into a registered output
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### rtl/core/salc_lookup.sv
// Set lookup: tag match, free-way and LRU victim choice, row update.
`timescale 1ns / 1ps

module salc_lookup #(
  parameter int MAX_WAYS = salc_pkg::MAX_WAYS_DEFAULT,
  parameter int TAG_W    = 20,
  parameter int WAY_W    = (MAX_WAYS > 1) ? $clog2(MAX_WAYS) : 1,
  parameter int CNT_W    = $clog2(MAX_WAYS + 1),
  parameter int ROW_W    = MAX_WAYS * (TAG_W + 1 + WAY_W)
) (
  input  logic [ROW_W-1:0]     row_in,
  input  logic                 row_fresh,
  input  logic [TAG_W-1:0]     tag,
  input  logic [CNT_W-1:0]     eff_ways,
  output logic [ROW_W-1:0]     row_out,
  output logic [TAG_W-1:0]     victim_tag,
  output salc_pkg::lookup_flags_t flags
);

  localparam int VLD_LO = MAX_WAYS * TAG_W;
  localparam int ORD_LO = VLD_LO + MAX_WAYS;

  logic [TAG_W-1:0] tags      [MAX_WAYS];
  logic [MAX_WAYS-1:0] valid;
  logic [WAY_W-1:0] order     [MAX_WAYS];
  logic [TAG_W-1:0] tags_new  [MAX_WAYS];
  logic [MAX_WAYS-1:0] valid_new;
  logic [WAY_W-1:0] order_new [MAX_WAYS];
  logic [CNT_W-1:0] used;
  logic             found;
  logic [WAY_W-1:0] hit_way;
  logic [WAY_W-1:0] free_way;
  logic [WAY_W-1:0] lru_way;
  logic [WAY_W-1:0] way;
  logic             use_free;
  logic [WAY_W-1:0] pos;

  // Unpack the row; a set never written reads as its reset contents
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tags[w]  = row_in[w*TAG_W +: TAG_W];
      valid[w] = row_fresh & row_in[VLD_LO + w];
      order[w] = row_fresh ? row_in[ORD_LO + w*WAY_W +: WAY_W] : WAY_W'(w);
    end
  end

  // Search the set: occupancy, first matching way, lowest free way
  always_comb begin
    used     = '0;
    found    = 1'b0;
    hit_way  = '0;
    free_way = '0;
    for (int w = MAX_WAYS - 1; w >= 0; w--) begin
      used = used + CNT_W'(valid[w]);
      if (valid[w] && (tags[w] == tag)) begin
        found   = 1'b1;
        hit_way = WAY_W'(w);
      end
      if (!valid[w]) begin
        free_way = WAY_W'(w);
      end
    end
  end

  // Pick the least recently used valid way
  always_comb begin
    lru_way = '0;
    for (int p = 0; p < MAX_WAYS; p++) begin
      if (valid[order[p]]) begin
        lru_way = order[p];
      end
    end
  end

  assign use_free = (used < eff_ways);
  assign way      = found ? hit_way : (use_free ? free_way : lru_way);
  assign victim_tag = tags[way];
  assign flags.hit   = found;
  assign flags.evict = !found && !use_free;

  // Locate the chosen way in the recency list
  always_comb begin
    pos = WAY_W'(MAX_WAYS - 1);
    for (int p = 0; p < MAX_WAYS; p++) begin
      if (order[p] == way) begin
        pos = WAY_W'(p);
      end
    end
  end

  // Fill the way on a miss and move it to the front of the list
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      tags_new[w]  = (!found && (way == WAY_W'(w))) ? tag : tags[w];
      valid_new[w] = valid[w] | (way == WAY_W'(w));
    end
    order_new[0] = way;
    for (int p = 1; p < MAX_WAYS; p++) begin
      order_new[p] = (WAY_W'(p) <= pos) ? order[p-1] : order[p];
    end
  end

  // Pack the updated row
  always_comb begin
    for (int w = 0; w < MAX_WAYS; w++) begin
      row_out[w*TAG_W +: TAG_W]         = tags_new[w];
      row_out[VLD_LO + w]               = valid_new[w];
      row_out[ORD_LO + w*WAY_W +: WAY_W] = order_new[w];
    end
  end

endmodule
